>>> hw/rtl/semantic_pixel_match_scorer_assert.svh
// Assertion macros for the semantic pixel match scorer checker.
// Needs signals clk and rst_n in the scope where the macros are used.
`ifndef SEMANTIC_PIXEL_MATCH_SCORER_ASSERT_SVH
`define SEMANTIC_PIXEL_MATCH_SCORER_ASSERT_SVH

// Same-cycle implication, disabled during reset
`define SPMS_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("spms assertion failed");

// Next-cycle implication, disabled during reset
`define SPMS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("spms assertion failed");

`endif

>>> hw/rtl/spms_pkg.sv
// Shared types and constants for the semantic pixel match scorer.
// No dependencies; imported by every module of the block.
package spms_pkg;

    localparam int FRAME_SCORE_W   = 29;
    localparam int FRAME_MATCHES_W = 22;

    // Configuration register indexes
    typedef enum logic [2:0] {
        CFG_EXACT_TOL   = 3'd0,
        CFG_W_EXACT     = 3'd1,
        CFG_W_ROAD      = 3'd2,
        CFG_W_SIDEWALK  = 3'd3,
        CFG_W_CAR       = 3'd4,
        CFG_W_BUILDING  = 3'd5,
        CFG_W_TERRAIN   = 3'd6
    } cfg_idx_t;

    // Register reset values
    localparam logic [7:0] RST_EXACT_TOL  = 8'd10;
    localparam logic [7:0] RST_W_EXACT    = 8'd10;
    localparam logic [7:0] RST_W_ROAD     = 8'd7;
    localparam logic [7:0] RST_W_SIDEWALK = 8'd15;
    localparam logic [7:0] RST_W_CAR      = 8'd100;
    localparam logic [7:0] RST_W_BUILDING = 8'd7;
    localparam logic [7:0] RST_W_TERRAIN  = 8'd20;

    // Class colour centres (blue, green, red) and windows
    localparam logic [7:0] ROAD_B = 8'd128, ROAD_G = 8'd64,  ROAD_R = 8'd128;
    localparam logic [7:0] SIDE_B = 8'd232, SIDE_G = 8'd35,  SIDE_R = 8'd244;
    localparam logic [7:0] CAR_B  = 8'd142, CAR_G  = 8'd0,   CAR_R  = 8'd0;
    localparam logic [7:0] BLDG_B = 8'd70,  BLDG_G = 8'd70,  BLDG_R = 8'd70;
    localparam logic [7:0] TERR_B = 8'd152, TERR_G = 8'd251, TERR_R = 8'd152;
    localparam logic [7:0] WIN_NARROW = 8'd5;
    localparam logic [7:0] WIN_WIDE   = 8'd10;
    localparam logic [7:0] ROAD_RB_TOL = 8'd10;
    localparam logic [7:0] SIDE_RB_TOL = 8'd15;
    localparam logic [7:0] CAR_DARK    = 8'd10;
    localparam logic [7:0] BLDG_TOL    = 8'd5;
    localparam logic [7:0] TERR_RB_TOL = 8'd5;

    typedef struct packed {
        logic [7:0] exact_tolerance;
        logic [7:0] weight_exact;
        logic [7:0] weight_road;
        logic [7:0] weight_sidewalk;
        logic [7:0] weight_car;
        logic [7:0] weight_building;
        logic [7:0] weight_terrain;
    } cfg_t;

    typedef struct packed {
        logic [7:0] seg_blue;
        logic [7:0] seg_green;
        logic [7:0] seg_red;
        logic [7:0] map_blue;
        logic [7:0] map_green;
        logic [7:0] map_red;
        logic       frame_end;
    } pixel_t;

    typedef struct packed {
        logic [7:0]                 out_blue;
        logic [7:0]                 out_green;
        logic [7:0]                 out_red;
        logic [7:0]                 pixel_weight;
        logic                       frame_done;
        logic [FRAME_SCORE_W-1:0]   frame_score;
        logic [FRAME_MATCHES_W-1:0] frame_matches;
    } result_t;

endpackage

>>> hw/rtl/semantic_pixel_match_scorer.sv
// Semantic pixel match scorer, top level. Depends on spms_pkg.
// Pipeline: 2 register stages; a request leaves the input register once the output is free.
// Throughput: one pixel per cycle unless stalled; input register, rule logic, result register.
// While a result waits on stall the input register takes one more request, then input stalls.
// Reset clears valids and frame totals and loads register defaults.
module semantic_pixel_match_scorer
    import spms_pkg::*;
#(
    parameter int MAX_PIXELS = 2097152
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       pixel_valid,
    output logic       pixel_stall,
    input  pixel_t     pixel,
    output logic       result_valid,
    input  logic       result_stall,
    output result_t    result,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [2:0] cfg_index,
    input  logic [7:0] cfg_data
);

    cfg_t       cfg;
    pixel_t     s1_pix_reg;
    logic       s1_valid_reg, s1_valid_next;
    logic       out_valid_reg, out_valid_next;
    logic       out_free;
    logic       advance;
    logic       load_s1;
    logic [7:0] weight;

    assign cfg_ready = 1'b1;

    spms_cfg_regs u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    // Pipeline flow control
    assign out_free    = !out_valid_reg || !result_stall;
    assign advance     = s1_valid_reg && out_free;
    assign pixel_stall = s1_valid_reg && !out_free;
    assign load_s1     = pixel_valid && !pixel_stall;

    always_comb
    begin
        if (load_s1)
            s1_valid_next = 1'b1;
        else if (advance)
            s1_valid_next = 1'b0;
        else
            s1_valid_next = s1_valid_reg;

        if (advance)
            out_valid_next = 1'b1;
        else if (out_free)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Input payload register
    always_ff @(posedge clk)
    begin
        if (load_s1)
            s1_pix_reg <= pixel;
    end

    spms_rules u_rules (
        .pix    (s1_pix_reg),
        .cfg    (cfg),
        .weight (weight)
    );

    spms_accum #(
        .MAX_PIXELS (MAX_PIXELS)
    ) u_accum (
        .clk    (clk),
        .rst_n  (rst_n),
        .load   (advance),
        .pix    (s1_pix_reg),
        .weight (weight),
        .result (result)
    );

    assign result_valid = out_valid_reg;

endmodule

>>> hw/rtl/spms_cfg_regs.sv
// Configuration register file: seven 8-bit registers, written by index.
// Depends on spms_pkg.
module spms_cfg_regs
    import spms_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       wr_en,
    input  logic [2:0] wr_index,
    input  logic [7:0] wr_data,
    output cfg_t       cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // Write decode; unknown indexes are dropped
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (wr_index)
                CFG_EXACT_TOL:  cfg_next.exact_tolerance = wr_data;
                CFG_W_EXACT:    cfg_next.weight_exact    = wr_data;
                CFG_W_ROAD:     cfg_next.weight_road     = wr_data;
                CFG_W_SIDEWALK: cfg_next.weight_sidewalk = wr_data;
                CFG_W_CAR:      cfg_next.weight_car      = wr_data;
                CFG_W_BUILDING: cfg_next.weight_building = wr_data;
                CFG_W_TERRAIN:  cfg_next.weight_terrain  = wr_data;
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.exact_tolerance <= RST_EXACT_TOL;
            cfg_reg.weight_exact    <= RST_W_EXACT;
            cfg_reg.weight_road     <= RST_W_ROAD;
            cfg_reg.weight_sidewalk <= RST_W_SIDEWALK;
            cfg_reg.weight_car      <= RST_W_CAR;
            cfg_reg.weight_building <= RST_W_BUILDING;
            cfg_reg.weight_terrain  <= RST_W_TERRAIN;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

>>> hw/rtl/spms_rules.sv
// Class rule evaluation: picks the weight of the first matching rule.
// Pure combinational; depends on spms_pkg.
module spms_rules
    import spms_pkg::*;
(
    input  pixel_t     pix,
    input  cfg_t       cfg,
    output logic [7:0] weight
);

    function automatic logic [7:0] absdiff(input logic [7:0] a, input logic [7:0] b);
        return (a > b) ? (a - b) : (b - a);
    endfunction

    function automatic logic near3(
        input logic [7:0] sb, input logic [7:0] sg, input logic [7:0] sr,
        input logic [7:0] cb, input logic [7:0] cg, input logic [7:0] cr,
        input logic [7:0] win);
        return (absdiff(sb, cb) < win) && (absdiff(sg, cg) < win) &&
               (absdiff(sr, cr) < win);
    endfunction

    logic       map_black;
    logic       hit_exact, hit_road, hit_side, hit_car, hit_bldg, hit_terr;
    logic [9:0] g_x4;       // 4 * map green
    logic [10:0] g1_x4_w;   // 4 * (map green + 1), at most 1024

    // Ratio tests as shifts of the green channel
    assign g_x4    = {pix.map_green, 2'b00};
    assign g1_x4_w = {1'b0, g_x4} + 11'd4;

    assign map_black = (pix.map_blue == 8'd0) && (pix.map_green == 8'd0) &&
                       (pix.map_red == 8'd0);

    assign hit_exact = near3(pix.seg_blue, pix.seg_green, pix.seg_red,
                             pix.map_blue, pix.map_green, pix.map_red,
                             cfg.exact_tolerance);

    // road: map red and blue close, both below 4*(green+1)
    assign hit_road = near3(pix.seg_blue, pix.seg_green, pix.seg_red,
                            ROAD_B, ROAD_G, ROAD_R, WIN_NARROW) &&
                      (absdiff(pix.map_red, pix.map_blue) < ROAD_RB_TOL) &&
                      ({3'b000, pix.map_red} < g1_x4_w) &&
                      ({3'b000, pix.map_blue} < g1_x4_w);

    // sidewalk: red and blue dominate four times the green
    assign hit_side = near3(pix.seg_blue, pix.seg_green, pix.seg_red,
                            SIDE_B, SIDE_G, SIDE_R, WIN_NARROW) &&
                      (absdiff(pix.map_red, pix.map_blue) < SIDE_RB_TOL) &&
                      ({2'b00, pix.map_red} > g_x4) &&
                      ({2'b00, pix.map_blue} > g_x4);

    // car: blue map with dark red and green
    assign hit_car = near3(pix.seg_blue, pix.seg_green, pix.seg_red,
                           CAR_B, CAR_G, CAR_R, WIN_NARROW) &&
                     (pix.map_green < CAR_DARK) && (pix.map_red < CAR_DARK) &&
                     (pix.map_blue > CAR_DARK);

    // building: grey map pixel
    assign hit_bldg = near3(pix.seg_blue, pix.seg_green, pix.seg_red,
                            BLDG_B, BLDG_G, BLDG_R, WIN_NARROW) &&
                      (absdiff(pix.map_red, pix.map_green) < BLDG_TOL) &&
                      (absdiff(pix.map_green, pix.map_blue) < BLDG_TOL) &&
                      (absdiff(pix.map_blue, pix.map_red) < BLDG_TOL);

    // terrain: green dominant map pixel
    assign hit_terr = near3(pix.seg_blue, pix.seg_green, pix.seg_red,
                            TERR_B, TERR_G, TERR_R, WIN_WIDE) &&
                      (absdiff(pix.map_red, pix.map_blue) < TERR_RB_TOL) &&
                      (pix.map_green > pix.map_blue) &&
                      (pix.map_green > pix.map_red);

    // Priority select; first hit ends the search even with a zero weight
    always_comb
    begin
        if (map_black)
            weight = 8'd0;
        else if (hit_exact)
            weight = cfg.weight_exact;
        else if (hit_road)
            weight = cfg.weight_road;
        else if (hit_side)
            weight = cfg.weight_sidewalk;
        else if (hit_car)
            weight = cfg.weight_car;
        else if (hit_bldg)
            weight = cfg.weight_building;
        else if (hit_terr)
            weight = cfg.weight_terrain;
        else
            weight = 8'd0;
    end

endmodule

>>> hw/rtl/spms_accum.sv
// Frame accumulators (saturating score and match count) and result register.
// Depends on spms_pkg.
module spms_accum
    import spms_pkg::*;
#(
    parameter int MAX_PIXELS = 2097152
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       load,
    input  pixel_t     pix,
    input  logic [7:0] weight,
    output result_t    result
);

    localparam longint unsigned SCORE_MAX_L = 64'd255 * 64'(MAX_PIXELS);
    localparam int SCORE_BITS = $clog2(SCORE_MAX_L + 64'd1);
    localparam int CNT_BITS   = $clog2(64'(MAX_PIXELS) + 64'd1);
    localparam int SCORE_W = (SCORE_BITS > FRAME_SCORE_W) ? SCORE_BITS : FRAME_SCORE_W;
    localparam int CNT_W   = (CNT_BITS > FRAME_MATCHES_W) ? CNT_BITS : FRAME_MATCHES_W;
    localparam logic [SCORE_W:0]  SCORE_MAX = (SCORE_W+1)'(SCORE_MAX_L);
    localparam logic [CNT_W-1:0]  CNT_MAX   = CNT_W'(MAX_PIXELS);

    logic [SCORE_W-1:0] score_reg, score_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    result_t            result_reg, result_next;

    logic               matched;
    logic [SCORE_W:0]   score_add;
    logic [SCORE_W-1:0] score_upd;
    logic [CNT_W-1:0]   count_upd;

    assign matched = (weight != 8'd0);

    // Saturating score add and match count
    always_comb
    begin
        score_add = {1'b0, score_reg} + (SCORE_W+1)'(weight);
        if (!matched)
            score_upd = score_reg;
        else if (score_add > SCORE_MAX)
            score_upd = SCORE_MAX[SCORE_W-1:0];
        else
            score_upd = score_add[SCORE_W-1:0];

        if (matched && (count_reg < CNT_MAX))
            count_upd = count_reg + CNT_W'(1);
        else
            count_upd = count_reg;
    end

    // Result payload and accumulator next state
    always_comb
    begin
        score_next  = score_reg;
        count_next  = count_reg;
        result_next = result_reg;
        if (load)
        begin
            result_next.out_blue     = matched ? pix.map_blue  : 8'd0;
            result_next.out_green    = matched ? pix.map_green : 8'd0;
            result_next.out_red      = matched ? pix.map_red   : 8'd0;
            result_next.pixel_weight = weight;
            result_next.frame_done   = pix.frame_end;
            if (pix.frame_end)
            begin
                result_next.frame_score   = score_upd[FRAME_SCORE_W-1:0];
                result_next.frame_matches = count_upd[FRAME_MATCHES_W-1:0];
                score_next = '0;
                count_next = '0;
            end
            else
            begin
                result_next.frame_score   = '0;
                result_next.frame_matches = '0;
                score_next = score_upd;
                count_next = count_upd;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            score_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            score_reg <= score_next;
            count_reg <= count_next;
        end
    end

    // Payload register, no reset
    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign result = result_reg;

endmodule

>>> hw/rtl/spms_checker.sv
// Port-level checker for the semantic pixel match scorer, with its bind.
// Depends on spms_pkg and semantic_pixel_match_scorer_assert.svh.
`include "semantic_pixel_match_scorer_assert.svh"

module spms_checker
    import spms_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       result_valid,
    input logic       result_stall,
    input result_t    result
);

    // Totals only show on the frame-end result
    `SPMS_ASSERT_NOW(a_totals_only_at_end,
        result_valid && !result.frame_done,
        result.frame_score == '0 && result.frame_matches == '0)

    // An unmatched pixel comes out black
    `SPMS_ASSERT_NOW(a_unmatched_black,
        result_valid && result.pixel_weight == 8'd0,
        result.out_blue == 8'd0 && result.out_green == 8'd0 && result.out_red == 8'd0)

    // A matched pixel never shows a black colour
    `SPMS_ASSERT_NOW(a_matched_not_black,
        result_valid && result.pixel_weight != 8'd0,
        result.out_blue != 8'd0 || result.out_green != 8'd0 || result.out_red != 8'd0)

    // A stalled result holds
    `SPMS_ASSERT_NEXT(a_result_hold,
        result_valid && result_stall,
        result_valid && $stable(result))

endmodule

bind semantic_pixel_match_scorer spms_checker u_spms_checker (.*);
